// File: design/gtsc_pkg.sv
// Shared constants, profile tables, Gaussian table and types of the shape classifier.
`default_nettype none
package gtsc_pkg;

    localparam int NUM_PROFILES    = 13;
    localparam int NUM_FEATURES    = 15;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int FIDX_W    = 4;
    localparam int VAL_W     = 16;
    localparam int SCORE_W   = 16;
    localparam int CLASS_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int PIDX_W    = $clog2(NUM_PROFILES);
    localparam int FCNT_W    = $clog2(NUM_FEATURES);

    localparam int GAUSS_W     = 17;
    localparam int WEIGHT_W    = 7;
    localparam int SIGMA_W     = 13;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 34;
    localparam int IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int IDX_SH      = IDX_W - 3;           // index = |d| * DEPTH / (8 sigma)
    localparam int AD_W        = 17;
    localparam int ADLO_W      = 15;                  // |d| < 8 sigma <= 32768
    localparam int NSC_W       = ADLO_W + IDX_SH;
    localparam int PROD_W      = NSC_W + RECIP_W;
    localparam int WS_W        = WEIGHT_W + GAUSS_W;
    localparam int NUM_W       = 28;
    localparam int DEN_W       = 11;
    localparam int DCNT_W      = $clog2(NUM_W);

    localparam logic [CLASS_W-1:0]   CLASS_UNKNOWN    = 4'd13;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIGUITY    = 1'b1;
    localparam logic [CFG_W-1:0]     REJECT_RESET     = 16'd29491;
    localparam logic [CFG_W-1:0]     AMBIGUITY_RESET  = 16'd3277;
    localparam logic [63:0]          EXP_NEG_ONE_Q32  = 64'd1580030169;

    typedef logic [GAUSS_W-1:0] gauss_rom_t [EXP_TABLE_DEPTH];

    typedef struct packed {
        logic                    clear;
        logic                    issue;
        logic [FCNT_W-1:0]       feat;
        logic [PIDX_W-1:0]       prof;
        logic signed [VAL_W-1:0] value;
    } mac_req_t;

    typedef struct packed {
        logic busy;
        logic acc_pending;
    } mac_stat_t;

    localparam logic signed [VAL_W-1:0] EXPECT [NUM_PROFILES][NUM_FEATURES] = '{
        '{16'sd1966, 16'sd2867, 16'sd3768, 16'sd2294, 16'sd2253, 16'sd2048, 16'sd4096, 16'sd0,
          16'sd3768, 16'sd3850, 16'sd3912, 16'sd4096, 16'sd4096, 16'sd2540, 16'sd8192},
        '{16'sd3850, 16'sd4096, 16'sd2048, 16'sd4055, 16'sd1024, 16'sd0, 16'sd2048, 16'sd315,
          16'sd4055, 16'sd4055, 16'sd4055, 16'sd4096, 16'sd1024, 16'sd2458, 16'sd8192},
        '{16'sd1966, 16'sd2458, 16'sd3359, 16'sd1843, 16'sd819, 16'sd2048, 16'sd4096, 16'sd0,
          16'sd3072, 16'sd3072, 16'sd3809, 16'sd4096, 16'sd4096, 16'sd2662, 16'sd8192},
        '{16'sd3523, 16'sd4096, 16'sd2048, 16'sd3932, 16'sd2540, 16'sd1311, 16'sd2703, 16'sd242,
          16'sd4055, 16'sd4055, 16'sd369, 16'sd8192, 16'sd1024, 16'sd2130, 16'sd20480},
        '{16'sd1720, 16'sd3891, 16'sd3686, 16'sd4092, 16'sd2335, 16'sd2908, 16'sd3604, 16'sd86,
          16'sd4014, 16'sd4055, 16'sd942, 16'sd12288, 16'sd1024, 16'sd4055, 16'sd8192},
        '{16'sd1925, 16'sd3400, 16'sd2048, 16'sd3154, 16'sd3686, 16'sd2826, 16'sd3318, 16'sd139,
          16'sd4055, 16'sd4055, 16'sd614, 16'sd4096, 16'sd1024, 16'sd2146, 16'sd20480},
        '{16'sd1311, 16'sd3727, 16'sd696, 16'sd1229, 16'sd3850, 16'sd4096, 16'sd4096, 16'sd0,
          16'sd3932, 16'sd3891, 16'sd778, 16'sd4096, 16'sd4096, 16'sd2294, 16'sd8192},
        '{16'sd1966, 16'sd2949, 16'sd3768, 16'sd2253, 16'sd3154, 16'sd2130, 16'sd3891, 16'sd0,
          16'sd4055, 16'sd4055, 16'sd2253, 16'sd4096, 16'sd1024, 16'sd4096, 16'sd8192},
        '{16'sd3154, 16'sd3236, 16'sd2703, 16'sd3277, 16'sd2376, 16'sd2785, 16'sd3482, 16'sd164,
          16'sd4014, 16'sd4055, 16'sd2253, 16'sd4096, 16'sd1024, 16'sd2376, 16'sd16384},
        '{16'sd1720, 16'sd3809, 16'sd1024, 16'sd3236, 16'sd3154, 16'sd3482, 16'sd4096, 16'sd41,
          16'sd3973, 16'sd3973, 16'sd2089, 16'sd4096, 16'sd2048, 16'sd3072, 16'sd12288},
        '{16'sd1802, 16'sd3604, 16'sd2949, 16'sd2662, 16'sd3727, 16'sd1802, 16'sd4096, 16'sd0,
          16'sd3850, 16'sd3850, 16'sd3604, 16'sd4096, 16'sd4096, 16'sd2130, 16'sd16384},
        '{16'sd2294, 16'sd2540, 16'sd3564, 16'sd2376, 16'sd451, 16'sd4096, 16'sd4096, 16'sd0,
          16'sd3195, 16'sd3154, 16'sd3604, 16'sd16384, 16'sd4096, 16'sd3072, 16'sd12288},
        '{16'sd1843, 16'sd4014, 16'sd4055, 16'sd2007, 16'sd3686, 16'sd2130, 16'sd4096, 16'sd0,
          16'sd4055, 16'sd4055, 16'sd3768, 16'sd4096, 16'sd4096, 16'sd2253, 16'sd12288}
    };

    localparam logic [WEIGHT_W-1:0] WEIGHT [NUM_PROFILES][NUM_FEATURES] = '{
        '{7'd30, 7'd6, 7'd40, 7'd10, 7'd10, 7'd6, 7'd20, 7'd60, 7'd30, 7'd30, 7'd60, 7'd20, 7'd40,
          7'd10, 7'd10},
        '{7'd80, 7'd10, 7'd6, 7'd40, 7'd40, 7'd6, 7'd20, 7'd20, 7'd30, 7'd30, 7'd60, 7'd20, 7'd40,
          7'd10, 7'd20},
        '{7'd20, 7'd6, 7'd50, 7'd20, 7'd20, 7'd6, 7'd10, 7'd50, 7'd60, 7'd60, 7'd40, 7'd20, 7'd30,
          7'd10, 7'd10},
        '{7'd60, 7'd6, 7'd6, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd30, 7'd70, 7'd40, 7'd50,
          7'd10, 7'd50},
        '{7'd30, 7'd10, 7'd60, 7'd40, 7'd20, 7'd20, 7'd20, 7'd30, 7'd30, 7'd30, 7'd40, 7'd30, 7'd50,
          7'd80, 7'd30},
        '{7'd30, 7'd10, 7'd6, 7'd40, 7'd40, 7'd30, 7'd30, 7'd30, 7'd40, 7'd40, 7'd50, 7'd30, 7'd50,
          7'd70, 7'd40},
        '{7'd30, 7'd10, 7'd40, 7'd70, 7'd60, 7'd30, 7'd30, 7'd50, 7'd30, 7'd30, 7'd40, 7'd20, 7'd30,
          7'd20, 7'd30},
        '{7'd40, 7'd10, 7'd30, 7'd20, 7'd20, 7'd20, 7'd30, 7'd40, 7'd30, 7'd40, 7'd40, 7'd30, 7'd30,
          7'd40, 7'd30},
        '{7'd60, 7'd10, 7'd30, 7'd20, 7'd20, 7'd10, 7'd20, 7'd40, 7'd30, 7'd30, 7'd40, 7'd40, 7'd20,
          7'd40, 7'd40},
        '{7'd30, 7'd10, 7'd60, 7'd20, 7'd20, 7'd10, 7'd10, 7'd40, 7'd40, 7'd40, 7'd40, 7'd20, 7'd10,
          7'd20, 7'd20},
        '{7'd40, 7'd10, 7'd30, 7'd20, 7'd20, 7'd20, 7'd30, 7'd40, 7'd60, 7'd40, 7'd40, 7'd30, 7'd30,
          7'd60, 7'd30},
        '{7'd60, 7'd10, 7'd30, 7'd20, 7'd20, 7'd20, 7'd20, 7'd30, 7'd30, 7'd30, 7'd50, 7'd80, 7'd30,
          7'd30, 7'd60},
        '{7'd40, 7'd10, 7'd60, 7'd20, 7'd20, 7'd20, 7'd30, 7'd30, 7'd50, 7'd40, 7'd40, 7'd30, 7'd30,
          7'd40, 7'd30}
    };

    function automatic logic [SIGMA_W-1:0] sigma_of(input logic [FCNT_W-1:0] f);
        case (f)
            4'd0, 4'd3, 4'd4, 4'd13: sigma_of = 13'd1024;
            4'd1:                    sigma_of = 13'd1229;
            4'd2, 4'd5, 4'd6:        sigma_of = 13'd614;
            4'd7, 4'd8, 4'd9:        sigma_of = 13'd492;
            4'd10, 4'd12:            sigma_of = 13'd819;
            default:                 sigma_of = 13'd4096;
        endcase
    endfunction

    // ceil(2^34 / sigma)
    function automatic logic [RECIP_W-1:0] recip_of(input logic [FCNT_W-1:0] f);
        case (f)
            4'd0, 4'd3, 4'd4, 4'd13: recip_of = 26'd16777216;
            4'd1:                    recip_of = 26'd13978739;
            4'd2, 4'd5, 4'd6:        recip_of = 26'd27980243;
            4'd7, 4'd8, 4'd9:        recip_of = 26'd34918434;
            4'd10, 4'd12:            recip_of = 26'd20976642;
            default:                 recip_of = 26'd4194304;
        endcase
    endfunction

    function automatic logic [63:0] div_small(input logic [63:0] v, input int j);
        case (j)
            1:       div_small = v;
            2:       div_small = v / 2;
            3:       div_small = v / 3;
            4:       div_small = v / 4;
            5:       div_small = v / 5;
            6:       div_small = v / 6;
            7:       div_small = v / 7;
            8:       div_small = v / 8;
            9:       div_small = v / 9;
            10:      div_small = v / 10;
            11:      div_small = v / 11;
            12:      div_small = v / 12;
            default: div_small = v / 13;
        endcase
    endfunction

    function automatic logic [GAUSS_W-1:0] gauss_entry(input int k);
        logic [63:0] y;
        logic [63:0] n;
        logic [63:0] f;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] rnd;
        y = (64'(32 * k * k) << 32) / 64'(EXP_TABLE_DEPTH * EXP_TABLE_DEPTH);
        n = y >> 32;
        f = {32'd0, y[31:0]};
        sum = 64'd1 << 32;
        term = 64'd1 << 32;
        gauss_entry = '0;
        if (n < 64'd12)
        begin
            for (int j = 1; j <= 13; j++)
            begin
                term = div_small((term * f) >> 32, j);
                if ((j % 2) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            for (int j = 0; j < 12; j++)
            begin
                if (64'(j) < n)
                    sum = (sum * EXP_NEG_ONE_Q32) >> 32;
            end
            rnd = (sum * 64'd65536 + 64'h8000_0000) >> 32;
            gauss_entry = rnd[GAUSS_W-1:0];
        end
    endfunction

    function automatic gauss_rom_t build_gauss();
        gauss_rom_t t;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++)
            t[k] = gauss_entry(k);
        return t;
    endfunction

    localparam gauss_rom_t GAUSS_ROM = build_gauss();

endpackage
`default_nettype wire

// File: design/gtsc_if.sv
// Valid/ready channel interfaces for feature requests and classification results.
`default_nettype none
interface gtsc_feat_if;
    logic              valid;
    logic              ready;
    logic [3:0]        feature_index;
    logic signed [15:0] feature_value;
    logic              last_feature;

    modport source (output valid, feature_index, feature_value, last_feature, input ready);
    modport sink   (input valid, feature_index, feature_value, last_feature, output ready);
endinterface

interface gtsc_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  class_code;
    logic [15:0] confidence;
    logic [15:0] best_score;
    logic        ambiguous;

    modport source (output valid, class_code, confidence, best_score, ambiguous, input ready);
    modport sink   (input valid, class_code, confidence, best_score, ambiguous, output ready);
endinterface
`default_nettype wire

// File: design/gaussian_template_shape_classifier.sv
// Top level of the Gaussian template shape classifier: sequencer, feature store, result stage.
//
// Usage: feature requests arrive on feat_in, one feature per request (index, signed Q4.12
// value, last flag). Each request writes its feature into a 15-entry store; an index out
// of range is dropped. A request with last_feature set scores the stored vector against
// the 13 built-in profiles and yields one result request on res_out (class, confidence,
// best score, ambiguity flag). Requests without the last flag yield no result.
// Operation: a plain feature request only writes the store. A scoring request runs the shared
// weighted-similarity MAC one feature-profile pair a cycle, lets its pipeline drain and then
// runs the shared bit-serial divider, once per profile in turn.
// feat_in.ready is high only while the sequencer is idle. A finished result waits in the
// output register; the block takes new features while it waits, and a following scoring
// request stalls only at its final step until res_out takes the previous result.
// Configuration is written over cfg_we/cfg_index/cfg_data; the user must do so only while
// idle, as the block does not enforce it. Reset empties the pipeline and restores the
// thresholds; the feature store is not cleared and must be written before it is scored.
`default_nettype none
module gaussian_template_shape_classifier (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gtsc_feat_if.sink                           feat_in,
    gtsc_res_if.source                          res_out,
    input  wire logic                           cfg_we,
    input  wire logic [gtsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gtsc_pkg::CFG_W-1:0]     cfg_data
);
    import gtsc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FACT  = 3'd4;
    localparam logic [2:0] S_CONF  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [FCNT_W-1:0]       fc_reg;
    logic [PIDX_W-1:0]       pc_reg;
    logic signed [VAL_W-1:0] store_reg [NUM_FEATURES];
    logic [CFG_W-1:0]        reject_reg;
    logic [CFG_W-1:0]        ambig_reg;
    logic signed [17:0]      best_reg;
    logic signed [17:0]      second_reg;
    logic [CLASS_W-1:0]      cls_reg;
    logic [31:0]             fprod_reg;
    logic [32:0]             cprod_reg;
    logic                    ovalid_reg;
    logic [CLASS_W-1:0]      ocls_reg;
    logic [SCORE_W-1:0]      oconf_reg;
    logic [SCORE_W-1:0]      obest_reg;
    logic                    oamb_reg;

    mac_req_t               mac_req;
    mac_stat_t              mac_stat;
    logic [NUM_W-1:0]       acc_num;
    logic [DEN_W-1:0]       acc_den;
    logic                   div_start;
    logic                   div_done;
    logic [SCORE_W-1:0]     score;
    logic                   accept;
    logic signed [17:0]     score_s;
    logic [SCORE_W-1:0]     margin;
    logic [16:0]            m2;
    logic [16:0]            factor;
    logic [32:0]            conf_rnd;
    logic [SCORE_W-1:0]     conf_sat;
    logic                   out_free;

    assign accept          = feat_in.valid && feat_in.ready;
    assign feat_in.ready   = (state_reg == S_IDLE);
    assign out_free        = !ovalid_reg || res_out.ready;
    assign div_start       = (state_reg == S_DRAIN) && !mac_stat.busy;
    assign score_s         = {2'b00, score};

    always_comb
    begin
        mac_req.clear = (accept && feat_in.last_feature) || ((state_reg == S_DIV) && div_done);
        mac_req.issue = (state_reg == S_MAC);
        mac_req.feat  = fc_reg;
        mac_req.prof  = pc_reg;
        mac_req.value = store_reg[fc_reg];
    end

    gtsc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .stat  (mac_stat),
        .num   (acc_num),
        .den   (acc_den)
    );

    gtsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_num),
        .den   (acc_den),
        .done  (div_done),
        .quot  (score)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && feat_in.last_feature)
                    state_next = S_MAC;
            S_MAC:
                if (fc_reg == FCNT_W'(NUM_FEATURES - 1))
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!mac_stat.busy)
                    state_next = S_DIV;
            S_DIV:
                if (div_done)
                    state_next = (pc_reg == PIDX_W'(NUM_PROFILES - 1)) ? S_FACT : S_MAC;
            S_FACT:
                state_next = S_CONF;
            S_CONF:
                state_next = S_EMIT;
            S_EMIT:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fc_reg     <= '0;
            pc_reg     <= '0;
            reject_reg <= REJECT_RESET;
            ambig_reg  <= AMBIGUITY_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == REG_REJECT)
                reject_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_AMBIGUITY)
                ambig_reg <= cfg_data;

            if (accept)
            begin
                fc_reg <= '0;
                pc_reg <= '0;
            end
            else if (state_reg == S_MAC)
                fc_reg <= (fc_reg == FCNT_W'(NUM_FEATURES - 1)) ? '0 : fc_reg + 1'b1;
            else if (state_reg == S_DIV && div_done)
                pc_reg <= pc_reg + 1'b1;

            if (state_reg == S_EMIT && out_free)
                ovalid_reg <= 1'b1;
            else if (res_out.ready)
                ovalid_reg <= 1'b0;
        end
    end

    // feature store, ranking and result payload
    always_comb
    begin
        margin   = best_reg[15:0] - (second_reg[17] ? 16'd0 : second_reg[15:0]);
        m2       = margin[15] ? 17'h10000 : {margin, 1'b0};
        factor   = 17'd45875 + 17'((fprod_reg + 32'd32768) >> 16);
        conf_rnd = cprod_reg + 33'd32768;
        conf_sat = (conf_rnd[32:16] > 17'd65535) ? 16'hFFFF : conf_rnd[31:16];
    end

    always_ff @(posedge clk)
    begin
        if (accept && feat_in.feature_index < FIDX_W'(NUM_FEATURES))
            store_reg[FCNT_W'(feat_in.feature_index)] <= feat_in.feature_value;

        if (accept && feat_in.last_feature)
        begin
            best_reg   <= -18'sd1;
            second_reg <= -18'sd1;
            cls_reg    <= '0;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            // ties keep the earlier profile
            if (score_s > best_reg)
            begin
                second_reg <= best_reg;
                best_reg   <= score_s;
                cls_reg    <= CLASS_W'(pc_reg);
            end
            else if (score_s > second_reg)
                second_reg <= score_s;
        end

        if (state_reg == S_FACT)
            fprod_reg <= 32'(m2) * 32'd19661;
        if (state_reg == S_CONF)
            cprod_reg <= 33'(best_reg[15:0]) * 33'(factor);

        if (state_reg == S_EMIT && out_free)
        begin
            obest_reg <= best_reg[15:0];
            if (best_reg[15:0] < reject_reg)
            begin
                ocls_reg  <= CLASS_UNKNOWN;
                oconf_reg <= '0;
                oamb_reg  <= 1'b0;
            end
            else if (margin < ambig_reg)
            begin
                ocls_reg  <= cls_reg;
                oconf_reg <= conf_sat >> 1;
                oamb_reg  <= 1'b1;
            end
            else
            begin
                ocls_reg  <= cls_reg;
                oconf_reg <= conf_sat;
                oamb_reg  <= 1'b0;
            end
        end
    end

    assign res_out.valid      = ovalid_reg;
    assign res_out.class_code = ocls_reg;
    assign res_out.confidence = oconf_reg;
    assign res_out.best_score = obest_reg;
    assign res_out.ambiguous  = oamb_reg;

    ast_unknown_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (res_out.valid && res_out.class_code == CLASS_UNKNOWN)
            |-> (res_out.confidence == '0 && !res_out.ambiguous))
        else $error("unknown class carries confidence or ambiguity");

    ast_ready_no_work: assert property (@(posedge clk) disable iff (!rst_n)
        feat_in.ready |-> !mac_stat.busy)
        else $error("ready while the MAC pipeline holds work");

    ast_div_in_place: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

    ast_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !mac_stat.acc_pending)
        else $error("divide started before accumulation settled");
endmodule
`default_nettype wire

// File: design/gtsc_mac.sv
// Weighted Gaussian similarity pipeline and accumulators, one feature-profile pair per cycle.
`default_nettype none
module gtsc_mac (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gtsc_pkg::mac_req_t        req,
    output gtsc_pkg::mac_stat_t            stat,
    output logic [gtsc_pkg::NUM_W-1:0]     num,
    output logic [gtsc_pkg::DEN_W-1:0]     den
);
    import gtsc_pkg::*;

    logic                  v1_reg;
    logic                  v2_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  halve_reg;
    logic                  inr_reg;
    logic [WEIGHT_W-1:0]   w_reg;
    logic [WS_W-1:0]       ws_reg;
    logic [WEIGHT_W-1:0]   wh_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DEN_W-1:0]      den_reg;

    logic signed [AD_W-1:0] d;
    logic [AD_W-1:0]        ad;
    logic [SIGMA_W-1:0]     sig;
    logic [NSC_W-1:0]       nsc;
    logic [IDX_W-1:0]       tidx;
    logic [GAUSS_W-1:0]     s;
    logic [WEIGHT_W-1:0]    wh;

    // stage 1: distance, bounds and reciprocal multiply
    always_comb
    begin
        sig = sigma_of(req.feat);
        d   = AD_W'(req.value) - AD_W'(EXPECT[req.prof][req.feat]);
        ad  = d[AD_W-1] ? AD_W'(-d) : AD_W'(d);
        nsc = {ad[ADLO_W-1:0], {IDX_SH{1'b0}}};
    end

    // stage 2: table lookup and weighting
    always_comb
    begin
        tidx = prod_reg[RECIP_SHIFT +: IDX_W];
        s    = inr_reg ? GAUSS_ROM[tidx] : '0;
        wh   = halve_reg ? (w_reg >> 1) : w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(nsc) * PROD_W'(recip_of(req.feat));
        halve_reg <= ad > AD_W'(3 * sig);
        inr_reg   <= ad < AD_W'({sig, 3'b000});
        w_reg     <= WEIGHT[req.prof][req.feat];
        ws_reg    <= WS_W'(wh) * WS_W'(s);
        wh_reg    <= wh;
        if (req.clear)
        begin
            num_reg <= '0;
            den_reg <= '0;
        end
        else if (v2_reg)
        begin
            num_reg <= num_reg + NUM_W'(ws_reg);
            den_reg <= den_reg + DEN_W'(wh_reg);
        end
    end

    assign stat.busy        = v1_reg | v2_reg;
    assign stat.acc_pending = v2_reg;
    assign num = num_reg;
    assign den = den_reg;
endmodule
`default_nettype wire

// File: design/gtsc_div.sv
// Restoring divider, one quotient bit a cycle, rounded and saturated to a Q0.16 score.
`default_nettype none
module gtsc_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [gtsc_pkg::NUM_W-1:0]  num,
    input  wire logic [gtsc_pkg::DEN_W-1:0]  den,
    output logic                             done,
    output logic [gtsc_pkg::SCORE_W-1:0]     quot
);
    import gtsc_pkg::*;

    logic              run_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]  dvd_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W:0]    rem_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg[DEN_W-1:0], dvd_reg[NUM_W-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(NUM_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= num + NUM_W'(den >> 1);
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        end
    end

    assign done = done_reg;
    always_comb
    begin
        if (den_reg == '0)
            quot = '0;
        else if (q_reg[NUM_W-1:SCORE_W] != '0)
            quot = '1;
        else
            quot = q_reg[SCORE_W-1:0];
    end
endmodule
`default_nettype wire
